@@ src/wilder_rsi_stream_core_assert.svh @@
// Assertion macros used by the checker file of the RSI stream block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef WILDER_RSI_STREAM_CORE_ASSERT_SVH
`define WILDER_RSI_STREAM_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WRSI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WRSI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/wrsi_pkg.sv @@
`timescale 1ns / 1ps
package wrsi_pkg;

    localparam int PRICE_BITS   = 32;
    localparam int FRAC_BITS    = 16;
    localparam int PERIOD_BITS  = 10;
    localparam int COUNT_BITS   = PERIOD_BITS + 1;
    localparam int MAX_PERIOD   = 1023;
    localparam int PART_BITS    = PRICE_BITS + FRAC_BITS;
    localparam int AVG_BITS     = 58;
    localparam int REM_BITS     = AVG_BITS + 1;
    localparam int RSI_BITS     = 23;
    localparam int HUNDRED_BITS = 7;
    localparam int G100_BITS    = AVG_BITS + HUNDRED_BITS;
    localparam int DIV_CNT_BITS = 6;

    localparam logic [PERIOD_BITS-1:0]  PERIOD_RESET  = PERIOD_BITS'(14);
    localparam logic [DIV_CNT_BITS-1:0] DIV_P_STEPS   = DIV_CNT_BITS'(AVG_BITS);
    localparam logic [DIV_CNT_BITS-1:0] DIV_RSI_STEPS = DIV_CNT_BITS'(RSI_BITS);
    localparam logic [RSI_BITS-1:0]     RSI_FIFTY     = RSI_BITS'(50 << FRAC_BITS);
    localparam logic [RSI_BITS-1:0]     RSI_HUNDRED   = RSI_BITS'(100 << FRAC_BITS);

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_MULG,
        SEQ_MULL,
        SEQ_GSTART,
        SEQ_GWAIT,
        SEQ_LSTART,
        SEQ_LWAIT,
        SEQ_RSI,
        SEQ_RWAIT,
        SEQ_OUT
    } seq_state_t;

    // One long division job: starting remainder, dividend bits taken MSB first,
    // divisor and number of quotient bits to produce.
    typedef struct packed {
        logic [REM_BITS-1:0]     rem;
        logic [AVG_BITS-1:0]     num;
        logic [REM_BITS-1:0]     divisor;
        logic [DIV_CNT_BITS-1:0] steps;
    } div_cmd_t;

    typedef struct packed {
        logic                done;
        logic [AVG_BITS-1:0] quo;
    } div_rsp_t;

    typedef struct packed {
        logic                load;
        logic [RSI_BITS-1:0] rsi;
        logic                ok;
    } seq_res_t;

endpackage

@@ src/wrsi_div.sv @@
`timescale 1ns / 1ps
module wrsi_div
    import wrsi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  div_cmd_t cmd,
    output div_rsp_t rsp
);

    logic [REM_BITS-1:0]     rem_reg, rem_next;
    logic [AVG_BITS-1:0]     num_reg, num_next;
    logic [REM_BITS-1:0]     div_reg, div_next;
    logic [AVG_BITS-1:0]     quo_reg, quo_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [REM_BITS:0]       shifted;
    logic [REM_BITS:0]       diff;
    logic                    fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
    end

    // One restoring step per cycle: shift in the next dividend bit, subtract if it fits.
    assign shifted = {rem_reg, num_reg[AVG_BITS-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign fits    = (shifted >= {1'b0, div_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        num_next  = num_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = cmd.rem;
            num_next  = cmd.num;
            div_next  = cmd.divisor;
            quo_next  = '0;
            cnt_next  = cmd.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[REM_BITS-1:0] : shifted[REM_BITS-1:0];
            num_next = {num_reg[AVG_BITS-2:0], 1'b0};
            quo_next = {quo_reg[AVG_BITS-2:0], fits};
            cnt_next = cnt_reg - DIV_CNT_BITS'(1);
            if (cnt_reg == DIV_CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

@@ src/wrsi_seq.sv @@
`timescale 1ns / 1ps
module wrsi_seq
    import wrsi_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   clear,
    input  logic                   take,
    input  logic [PRICE_BITS-1:0]  price,
    input  logic [PERIOD_BITS-1:0] p_eff,
    input  logic                   out_free,
    input  div_rsp_t               div_rsp,
    output logic                   idle,
    output logic                   div_start,
    output div_cmd_t               div_cmd,
    output seq_res_t               res
);

    seq_state_t              state_reg, state_next;
    logic [PRICE_BITS-1:0]   last_reg, last_next;
    logic [COUNT_BITS-1:0]   seen_reg, seen_next;
    logic [AVG_BITS-1:0]     gain_reg, gain_next;
    logic [AVG_BITS-1:0]     loss_reg, loss_next;
    logic [PART_BITS-1:0]    gpart_reg, gpart_next;
    logic [PART_BITS-1:0]    lpart_reg, lpart_next;
    logic [RSI_BITS-1:0]     rsi_reg, rsi_next;
    logic                    ok_reg, ok_next;

    logic [COUNT_BITS-1:0]            p_cnt;
    logic [PERIOD_BITS-1:0]           p_less;
    logic [PART_BITS-1:0]             gpart_in;
    logic [PART_BITS-1:0]             lpart_in;
    logic [AVG_BITS-1:0]              mul_a;
    logic [AVG_BITS+PERIOD_BITS-1:0]  prod;
    logic [PART_BITS-1:0]             mul_part;
    logic [AVG_BITS-1:0]              smoothed;
    logic [G100_BITS-1:0]             g100;
    logic [REM_BITS-1:0]              total;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            last_reg  <= '0;
            seen_reg  <= '0;
            gain_reg  <= '0;
            loss_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
            seen_reg  <= seen_next;
            gain_reg  <= gain_next;
            loss_reg  <= loss_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gpart_reg <= gpart_next;
        lpart_reg <= lpart_next;
        rsi_reg   <= rsi_next;
        ok_reg    <= ok_next;
    end

    assign p_cnt  = {1'b0, p_eff};
    assign p_less = p_eff - PERIOD_BITS'(1);

    // The price step splits into a gain part and a loss part, both in Q.FRAC_BITS.
    always_comb
    begin
        gpart_in = '0;
        lpart_in = '0;
        if (price >= last_reg)
            gpart_in = {price - last_reg, {FRAC_BITS{1'b0}}};
        else
            lpart_in = {last_reg - price, {FRAC_BITS{1'b0}}};
    end

    // One multiplier serves both averages, one per cycle.
    assign mul_a    = (state_reg == SEQ_MULL) ? loss_reg : gain_reg;
    assign mul_part = (state_reg == SEQ_MULL) ? lpart_reg : gpart_reg;
    assign prod     = (AVG_BITS+PERIOD_BITS)'(mul_a) * (AVG_BITS+PERIOD_BITS)'(p_less);
    assign smoothed = prod[AVG_BITS-1:0] + AVG_BITS'(mul_part);

    // gain * 100 as shifted adds; the Q16 scaling is folded into the divider feed.
    assign g100  = {gain_reg, 6'b0} + {1'b0, gain_reg, 5'b0} + {4'b0, gain_reg, 2'b0};
    assign total = {1'b0, gain_reg} + {1'b0, loss_reg};

    assign idle = (state_reg == SEQ_IDLE);

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        seen_next  = seen_reg;
        gain_next  = gain_reg;
        loss_next  = loss_reg;
        gpart_next = gpart_reg;
        lpart_next = lpart_reg;
        rsi_next   = rsi_reg;
        ok_next    = ok_reg;
        div_start  = 1'b0;
        div_cmd    = '0;
        res.load   = 1'b0;
        res.rsi    = rsi_reg;
        res.ok     = ok_reg;

        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (clear)
                begin
                    last_next = '0;
                    seen_next = '0;
                    gain_next = '0;
                    loss_next = '0;
                end
                else if (take)
                begin
                    last_next  = price;
                    gpart_next = gpart_in;
                    lpart_next = lpart_in;
                    rsi_next   = '0;
                    ok_next    = 1'b0;
                    priority if (seen_reg == '0)
                    begin
                        seen_next  = COUNT_BITS'(1);
                        state_next = SEQ_OUT;
                    end
                    else if (seen_reg < p_cnt)
                    begin
                        gain_next  = gain_reg + AVG_BITS'(gpart_in);
                        loss_next  = loss_reg + AVG_BITS'(lpart_in);
                        seen_next  = seen_reg + COUNT_BITS'(1);
                        state_next = SEQ_OUT;
                    end
                    else if (seen_reg == p_cnt)
                    begin
                        // Last warm-up step: the sums become the dividends.
                        gain_next  = gain_reg + AVG_BITS'(gpart_in);
                        loss_next  = loss_reg + AVG_BITS'(lpart_in);
                        seen_next  = p_cnt + COUNT_BITS'(1);
                        state_next = SEQ_GSTART;
                    end
                    else
                    begin
                        seen_next  = p_cnt + COUNT_BITS'(1);
                        state_next = SEQ_MULG;
                    end
                end
            end
            SEQ_MULG:
            begin
                gain_next  = smoothed;
                state_next = SEQ_MULL;
            end
            SEQ_MULL:
            begin
                loss_next  = smoothed;
                state_next = SEQ_GSTART;
            end
            SEQ_GSTART:
            begin
                div_start       = 1'b1;
                div_cmd.rem     = '0;
                div_cmd.num     = gain_reg;
                div_cmd.divisor = REM_BITS'(p_eff);
                div_cmd.steps   = DIV_P_STEPS;
                state_next      = SEQ_GWAIT;
            end
            SEQ_GWAIT:
            begin
                if (div_rsp.done)
                begin
                    gain_next  = div_rsp.quo;
                    state_next = SEQ_LSTART;
                end
            end
            SEQ_LSTART:
            begin
                div_start       = 1'b1;
                div_cmd.rem     = '0;
                div_cmd.num     = loss_reg;
                div_cmd.divisor = REM_BITS'(p_eff);
                div_cmd.steps   = DIV_P_STEPS;
                state_next      = SEQ_LWAIT;
            end
            SEQ_LWAIT:
            begin
                if (div_rsp.done)
                begin
                    loss_next  = div_rsp.quo;
                    state_next = SEQ_RSI;
                end
            end
            SEQ_RSI:
            begin
                ok_next = 1'b1;
                if (loss_reg == '0)
                begin
                    rsi_next   = (gain_reg == '0) ? RSI_FIFTY : RSI_HUNDRED;
                    state_next = SEQ_OUT;
                end
                else
                begin
                    // The quotient is below 2^RSI_BITS, so the dividend's top bits
                    // already form the starting remainder.
                    div_start       = 1'b1;
                    div_cmd.rem     = REM_BITS'(g100[G100_BITS-1:HUNDRED_BITS]);
                    div_cmd.num     = {g100[HUNDRED_BITS-1:0], {FRAC_BITS{1'b0}},
                                       {(AVG_BITS-HUNDRED_BITS-FRAC_BITS){1'b0}}};
                    div_cmd.divisor = total;
                    div_cmd.steps   = DIV_RSI_STEPS;
                    state_next      = SEQ_RWAIT;
                end
            end
            SEQ_RWAIT:
            begin
                if (div_rsp.done)
                begin
                    rsi_next   = div_rsp.quo[RSI_BITS-1:0];
                    state_next = SEQ_OUT;
                end
            end
            SEQ_OUT:
            begin
                if (out_free)
                begin
                    res.load   = 1'b1;
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

endmodule

@@ src/wilder_rsi_stream_core.sv @@
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// input     in_valid / in_stall   price [31:0]
// output    out_valid / out_stall rsi [22:0], valid_res
// config    cfg_valid / cfg_ready period [9:0]
//
// A warm-up item skips the divider. An item that yields a defined RSI runs two
// 58-step divisions by the period and, unless the loss average is zero, one
// 23-step ratio division, on one restoring divider making one quotient bit per cycle.
// Reset sets the period to 14 and clears the stream; a period write clears it too.
// A finished beat waits in the output register, so a new price can be taken
// while out_stall holds the previous result.
module wilder_rsi_stream_core
    import wrsi_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [PRICE_BITS-1:0]  price,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [RSI_BITS-1:0]    rsi,
    output logic                   valid_res,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [PERIOD_BITS-1:0] period
);

    logic [PERIOD_BITS-1:0] period_reg;
    logic                   out_valid_reg;
    logic [RSI_BITS-1:0]    rsi_reg;
    logic                   valid_res_reg;
    logic [PERIOD_BITS-1:0] p_eff;
    logic                   idle;
    logic                   cfg_write;
    logic                   take;
    logic                   out_free;
    logic                   div_start;
    div_cmd_t               div_cmd;
    div_rsp_t               div_rsp;
    seq_res_t               res;

    // A pending period write holds off the input so that no price beat is dropped.
    assign cfg_ready = idle;
    assign in_stall  = !idle || cfg_valid;
    assign cfg_write = cfg_valid && cfg_ready;
    assign take      = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // A period of zero behaves as one.
    assign p_eff = (period_reg == '0) ? PERIOD_BITS'(1) : period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            period_reg <= PERIOD_RESET;
        else if (cfg_write)
            period_reg <= period;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res.load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            rsi_reg       <= res.rsi;
            valid_res_reg <= res.ok;
        end
    end

    assign out_valid = out_valid_reg;
    assign rsi       = rsi_reg;
    assign valid_res = valid_res_reg;

    wrsi_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (cfg_write),
        .take      (take),
        .price     (price),
        .p_eff     (p_eff),
        .out_free  (out_free),
        .div_rsp   (div_rsp),
        .idle      (idle),
        .div_start (div_start),
        .div_cmd   (div_cmd),
        .res       (res)
    );

    wrsi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .cmd   (div_cmd),
        .rsp   (div_rsp)
    );

endmodule

@@ src/wrsi_check.sv @@
`timescale 1ns / 1ps
`include "wilder_rsi_stream_core_assert.svh"
module wrsi_check
    import wrsi_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic [PRICE_BITS-1:0]  price,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [RSI_BITS-1:0]    rsi,
    input logic                   valid_res,
    input logic                   cfg_valid,
    input logic                   cfg_ready,
    input logic [PERIOD_BITS-1:0] period
);

    logic in_beat;
    logic cfg_beat;

    assign in_beat  = in_valid && !in_stall;
    assign cfg_beat = cfg_valid && cfg_ready && (period == period);

    // A held result beat keeps its contents.
    `WRSI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(rsi) && $stable(valid_res), "output beat changed while stalled")

    // Every price keeps the block busy for at least the following cycle.
    `WRSI_ASSERT_NEXT(a_busy_after_take, in_beat && (price == price), in_stall && !cfg_ready, "block took another beat right after a price")

    // Warm-up results carry a zero index.
    `WRSI_ASSERT_NOW(a_warmup_zero, out_valid && !valid_res, rsi == '0, "warm-up result with nonzero rsi")

    // A defined index never exceeds one hundred.
    `WRSI_ASSERT_NOW(a_rsi_range, out_valid && valid_res, rsi <= RSI_HUNDRED, "rsi above one hundred")

    // A period write restarts the stream, so the block is still idle right after it.
    `WRSI_ASSERT_NEXT(a_cfg_idle, cfg_beat && !in_valid, cfg_ready, "block left idle after a period write")

endmodule

bind wilder_rsi_stream_core wrsi_check u_wrsi_check (.*);
